>>> hdl/bal_pkg.sv
// Shared types, codes and helpers for the bounded array list engine.
// No dependencies; bal_front, bal_back, the core and the bench import this package.
`default_nettype none

package bal_pkg;

   // Request kinds as they arrive on the input channel
   typedef enum logic [3:0] {
      K_INS_FRONT = 4'd0,
      K_INS_BACK  = 4'd1,
      K_INS_AT    = 4'd2,
      K_DEL_FRONT = 4'd3,
      K_DEL_BACK  = 4'd4,
      K_DEL_AT    = 4'd5,
      K_SEARCH    = 4'd6,
      K_DISPLAY   = 4'd7,
      K_ROTATE    = 4'd8
   } kind_type;

   // Operation class assigned by the front end
   typedef enum logic [1:0] {
      CLS_INSERT = 2'd0,
      CLS_DELETE = 2'd1,
      CLS_SCAN   = 2'd2,
      CLS_ROTATE = 2'd3
   } cls_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_FOUND    = 3'd5,
      ST_LISTED   = 3'd6
   } status_type;

   // Most results one search or display may produce
   localparam int MAX_RESULTS = 8;
   localparam int HITS_W      = 4;

   // Input transaction
   typedef struct packed {
      logic [3:0]         kind;
      logic signed [31:0] value;
      logic [3:0]         position;
      logic [7:0]         rotate_count;
   } req_type;

   // Result transaction
   typedef struct packed {
      status_type         status;
      logic [2:0]         index;
      logic signed [31:0] value_out;
      logic               last;
   } rsp_type;

   // Classified command passed from front end to executor
   typedef struct packed {
      cls_type            cls;
      kind_type           kind;
      logic signed [31:0] value;
      logic [3:0]         position;
      logic [7:0]         rotate_count;
   } cmd_type;

   function automatic rsp_type make_rsp(input status_type st, input logic [2:0] idx,
                                        input logic signed [31:0] val, input logic lst);
      rsp_type r;
      r.status    = st;
      r.index     = idx;
      r.value_out = val;
      r.last      = lst;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/bal_fifo.sv
// Small register queue used between the front end, executor and result port.
// Depends on nothing; width and depth come from parameters (DEPTH >= 2).
`default_nettype none

module bal_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [FW-1:0]    fill_ff;
   logic             wr_en, rd_en;

   assign full    = (fill_ff == FW'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign wr_en   = push && !full;
   assign rd_en   = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (wr_en && !rd_en) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (rd_en && !wr_en) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/bal_front.sv
// Front end: accepts request transactions, classifies them, drops unknown kinds.
// Depends on bal_pkg; feeds the command queue ahead of the executor.
`default_nettype none

module bal_front
   import bal_pkg::*;
(
   input  logic    req_push,
   input  req_type req_item,
   output logic    req_full,
   output logic    cmd_push,
   output cmd_type cmd_item,
   input  logic    cmd_full
);

   logic    known;
   cls_type cls;

   // Kind decode
   always_comb begin
      known = 1'b1;
      cls   = CLS_INSERT;
      unique case (req_item.kind)
         K_INS_FRONT, K_INS_BACK, K_INS_AT: cls = CLS_INSERT;
         K_DEL_FRONT, K_DEL_BACK, K_DEL_AT: cls = CLS_DELETE;
         K_SEARCH, K_DISPLAY:               cls = CLS_SCAN;
         K_ROTATE:                          cls = CLS_ROTATE;
         default:                           known = 1'b0;
      endcase
   end

   // Unknown kinds are taken and discarded without a result
   assign req_full = cmd_full;
   assign cmd_push = req_push && !cmd_full && known;

   always_comb begin
      cmd_item.cls          = cls;
      cmd_item.kind         = kind_type'(req_item.kind);
      cmd_item.value        = req_item.value;
      cmd_item.position     = req_item.position;
      cmd_item.rotate_count = req_item.rotate_count;
   end

endmodule

`default_nettype wire

>>> hdl/bal_back.sv
// Executor: holds the list registers and carries out queued commands.
// Depends on bal_pkg; reads the command queue and writes the result queue.
`default_nettype none

module bal_back
   import bal_pkg::*;
#(
   parameter int CAPACITY = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd_item,
   input  logic    cmd_empty,
   output logic    cmd_pop,
   output logic    res_push,
   output rsp_type res_item,
   input  logic    res_full
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PW = ((CW > 4) ? CW : 4) + 1;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SCAN,
      B_FLUSH,
      B_ROT
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic [HITS_W-1:0]  hits_ff, hits_in;
   logic               pend_v_ff, pend_v_in;
   rsp_type            pend_ff, pend_in;
   logic signed [31:0] key_ff, key_in;
   logic               listall_ff, listall_in;
   logic [7:0]         rot_cnt_ff, rot_cnt_in;

   logic signed [31:0] entries_ff [CAPACITY];
   logic signed [31:0] prev_e [CAPACITY];
   logic signed [31:0] next_e [CAPACITY];

   logic               do_ins, do_del, do_rot;
   logic [CW-1:0]      slot;
   logic [CW-1:0]      rd_addr;
   logic signed [31:0] rd_data;
   logic [CW+2:0]      idx_wide;

   // Neighbor taps for the parallel shifts
   always_comb begin
      prev_e[0]          = '0;
      next_e[CAPACITY-1] = '0;
      for (int i = 1; i < CAPACITY; i++) begin
         prev_e[i] = entries_ff[i-1];
      end
      for (int i = 0; i < CAPACITY - 1; i++) begin
         next_e[i] = entries_ff[i+1];
      end
   end

   // Single read port: scan index, or the tail entry for a rotation step
   assign rd_addr  = (state_ff == B_SCAN) ? scan_idx_ff : count_ff - 1'b1;
   assign rd_data  = entries_ff[rd_addr[IW-1:0]];
   assign idx_wide = {3'b000, scan_idx_ff};

   // Command execution and result generation
   always_comb begin
      logic [PW-1:0] pos_w;
      logic [PW-1:0] cnt_w;
      logic          hit;
      logic          done;
      pos_w       = PW'(cmd_item.position);
      cnt_w       = PW'(count_ff);
      hit         = 1'b0;
      done        = 1'b0;
      cmd_pop     = 1'b0;
      res_push    = 1'b0;
      res_item    = make_rsp(ST_OK, 3'd0, 32'sd0, 1'b1);
      state_in    = state_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      hits_in     = hits_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      key_in      = key_ff;
      listall_in  = listall_ff;
      rot_cnt_in  = rot_cnt_ff;
      do_ins      = 1'b0;
      do_del      = 1'b0;
      do_rot      = 1'b0;
      slot        = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (!cmd_empty && !res_full) begin
               cmd_pop  = 1'b1;
               res_push = 1'b1;
               unique case (cmd_item.cls)
                  CLS_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        res_item = make_rsp(ST_FULL, 3'd0, 32'sd0, 1'b1);
                     end else if (cmd_item.kind == K_INS_FRONT) begin
                        do_ins = 1'b1;
                     end else if (cmd_item.kind == K_INS_BACK) begin
                        do_ins = 1'b1;
                        slot   = count_ff;
                     end else if (pos_w != '0 && pos_w <= cnt_w + 1'b1) begin
                        do_ins = 1'b1;
                        slot   = CW'(pos_w - 1'b1);
                     end else begin
                        res_item = make_rsp(ST_BADPOS, 3'd0, 32'sd0, 1'b1);
                     end
                     if (do_ins) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CLS_DELETE: begin
                     if (count_ff == '0) begin
                        res_item = make_rsp(ST_EMPTY, 3'd0, 32'sd0, 1'b1);
                     end else if (cmd_item.kind == K_DEL_FRONT) begin
                        do_del = 1'b1;
                     end else if (cmd_item.kind == K_DEL_BACK) begin
                        do_del = 1'b1;
                        slot   = count_ff - 1'b1;
                     end else if (pos_w != '0 && pos_w <= cnt_w) begin
                        do_del = 1'b1;
                        slot   = CW'(pos_w - 1'b1);
                     end else begin
                        res_item = make_rsp(ST_BADPOS, 3'd0, 32'sd0, 1'b1);
                     end
                     if (do_del) begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  CLS_SCAN: begin
                     if (count_ff == '0) begin
                        res_item = make_rsp(ST_EMPTY, 3'd0, 32'sd0, 1'b1);
                     end else begin
                        res_push    = 1'b0;
                        key_in      = cmd_item.value;
                        listall_in  = (cmd_item.kind == K_DISPLAY);
                        scan_idx_in = '0;
                        hits_in     = '0;
                        pend_v_in   = 1'b0;
                        state_in    = B_SCAN;
                     end
                  end
                  CLS_ROTATE: begin
                     if (count_ff == '0) begin
                        res_item = make_rsp(ST_EMPTY, 3'd0, 32'sd0, 1'b1);
                     end else begin
                        res_push   = 1'b0;
                        rot_cnt_in = cmd_item.rotate_count;
                        state_in   = B_ROT;
                     end
                  end
               endcase
            end
         end
         B_SCAN: begin
            // One entry per cycle unless res_full; a hit is held until last is known
            if (!res_full) begin
               hit = listall_ff || (rd_data == key_ff);
               if (hit) begin
                  if (pend_v_ff) begin
                     res_push      = 1'b1;
                     res_item      = pend_ff;
                     res_item.last = 1'b0;
                  end
                  pend_in   = make_rsp(listall_ff ? ST_LISTED : ST_FOUND, idx_wide[2:0],
                                       rd_data, 1'b1);
                  pend_v_in = 1'b1;
                  hits_in   = hits_ff + 1'b1;
               end
               done = (scan_idx_ff == count_ff - 1'b1) ||
                      (hit && hits_ff == HITS_W'(MAX_RESULTS - 1));
               scan_idx_in = scan_idx_ff + 1'b1;
               if (done) begin
                  state_in = B_FLUSH;
               end
            end
         end
         B_FLUSH: begin
            if (!res_full) begin
               res_push  = 1'b1;
               res_item  = pend_v_ff ? pend_ff : make_rsp(ST_NOTFOUND, 3'd0, 32'sd0, 1'b1);
               pend_v_in = 1'b0;
               state_in  = B_IDLE;
            end
         end
         B_ROT: begin
            // One single right rotation per cycle
            if (rot_cnt_ff == '0) begin
               if (!res_full) begin
                  res_push = 1'b1;
                  state_in = B_IDLE;
               end
            end else begin
               do_rot     = 1'b1;
               rot_cnt_in = rot_cnt_ff - 1'b1;
            end
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         count_ff  <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_v_ff <= pend_v_in;
      end
   end

   // Scan and rotation working registers
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      hits_ff     <= hits_in;
      pend_ff     <= pend_in;
      key_ff      <= key_in;
      listall_ff  <= listall_in;
      rot_cnt_ff  <= rot_cnt_in;
   end

   // List registers: parallel shifts for insert, delete and rotate
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (do_ins) begin
            if (CW'(i) == slot) begin
               entries_ff[i] <= cmd_item.value;
            end else if (CW'(i) > slot && CW'(i) <= count_ff) begin
               entries_ff[i] <= prev_e[i];
            end
         end else if (do_del) begin
            if (CW'(i) >= slot && CW'(i) < count_ff - 1'b1) begin
               entries_ff[i] <= next_e[i];
            end
         end else if (do_rot) begin
            if (i == 0) begin
               entries_ff[i] <= rd_data;
            end else if (CW'(i) < count_ff) begin
               entries_ff[i] <= prev_e[i];
            end
         end
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list count above capacity");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_SCAN || state_ff == B_ROT) |-> count_ff != '0)
      else $error("scan or rotation on an empty list");

   a_push_space: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result written into a full queue");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_IDLE && cmd_pop && cmd_item.cls == CLS_INSERT &&
       res_item.status == ST_OK) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("successful insert did not grow the list");
`endif

endmodule

`default_nettype wire

>>> hdl/bounded_array_list_engine_core.sv
// Bounded array list engine: an ordered list of up to CAPACITY signed 32-bit entries with
// insert, delete, search, display and rotate requests, queue-style ports on both sides.
// A front end takes one request transaction per cycle, unless the command queue is full,
// into a 4-deep command queue while the executor works; results leave through a 2-deep
// result queue. The executor answers an insert or delete as it pops it; a search or
// display is dispatched, reads one entry per cycle through the list's single read port
// while the result queue has room, stops early after 8 hits, and flushes the held result;
// a rotate is dispatched, does one single-step rotation per cycle, gives its result. Unknown
// kinds are accepted and give no result. Depends on bal_pkg, bal_front, bal_fifo, bal_back.
`default_nettype none

module bounded_array_list_engine_core
   import bal_pkg::*;
#(
   parameter int CAPACITY = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_item,
   output logic    req_full,
   input  logic    rsp_pop,
   output rsp_type rsp_item,
   output logic    rsp_empty
);

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_in, cmd_out;
   logic    res_push, res_full;
   rsp_type res_item;

   bal_front u_front (
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .cmd_push (cmd_push),
      .cmd_item (cmd_in),
      .cmd_full (cmd_full)
   );

   bal_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_in),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_out),
      .empty   (cmd_empty)
   );

   bal_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_item  (cmd_out),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .res_push  (res_push),
      .res_item  (res_item),
      .res_full  (res_full)
   );

   bal_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_item),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (rsp_item),
      .empty   (rsp_empty)
   );

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for bounded_array_list_engine_core: a directed table, then random
// list traffic, checked against expected statuses or a local model of the list in this file.
// Depends on bal_pkg (request/result types, kind and status codes) and the core RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bal_pkg::*;

   localparam int LIST_CAP = 8;
   localparam int RANDOM_ITEMS = 104;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 600;
   // highest code of the kind field that names no operation
   localparam logic [3:0] KIND_SPARE = 4'hF;

   typedef struct {
      req_type    rq;
      bit         typed;
      status_type st;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_push;
   req_type req_item;
   logic    req_full;
   logic    rsp_pop;
   rsp_type rsp_item;
   logic    rsp_empty;

   // local copy of the list
   logic signed [31:0] list_q [LIST_CAP];
   int                 list_len;

   rsp_type     step_rsp[$];      // results caused by the transaction just accepted
   rsp_type     pending_rsp[$];   // results still owed by the core, oldest first
   dir_row_type dir_rows[$];
   int          n_errors;
   bit          snd_burst;
   bit          rcv_burst;
   bit          hold_req;

   bounded_array_list_engine_core #(
      .CAPACITY(LIST_CAP)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_item(req_item),
      .req_full(req_full),
      .rsp_pop(rsp_pop),
      .rsp_item(rsp_item),
      .rsp_empty(rsp_empty)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void add_single(input status_type st);
      rsp_type r;
      r.status    = st;
      r.index     = 3'd0;
      r.value_out = 32'sd0;
      r.last      = 1'b1;
      step_rsp.push_back(r);
   endfunction

   // Update the local list for one transaction and collect the results it causes
   function automatic void apply_req(input req_type rq);
      logic signed [31:0] rot_buf [LIST_CAP];
      rsp_type r;
      int slot;
      int sh;
      step_rsp.delete();
      case (rq.kind)
         K_INS_FRONT, K_INS_BACK, K_INS_AT: begin
            if (list_len >= LIST_CAP) begin
               add_single(ST_FULL);
            end else if (rq.kind == K_INS_AT &&
                         (rq.position < 1 || rq.position > list_len + 1)) begin
               add_single(ST_BADPOS);
            end else begin
               slot = (rq.kind == K_INS_FRONT) ? 0 :
                      (rq.kind == K_INS_BACK) ? list_len : int'(rq.position) - 1;
               for (int i = list_len; i > slot; i--) list_q[i] = list_q[i - 1];
               list_q[slot] = rq.value;
               list_len++;
               add_single(ST_OK);
            end
         end
         K_DEL_FRONT, K_DEL_BACK, K_DEL_AT: begin
            if (list_len == 0) begin
               add_single(ST_EMPTY);
            end else if (rq.kind == K_DEL_AT &&
                         (rq.position < 1 || rq.position > list_len)) begin
               add_single(ST_BADPOS);
            end else begin
               slot = (rq.kind == K_DEL_FRONT) ? 0 :
                      (rq.kind == K_DEL_BACK) ? list_len - 1 : int'(rq.position) - 1;
               for (int i = slot; i + 1 < list_len; i++) list_q[i] = list_q[i + 1];
               list_len--;
               add_single(ST_OK);
            end
         end
         K_SEARCH, K_DISPLAY: begin
            if (list_len == 0) begin
               add_single(ST_EMPTY);
            end else begin
               for (int i = 0; i < list_len && step_rsp.size() < MAX_RESULTS; i++) begin
                  if (rq.kind == K_DISPLAY || list_q[i] == rq.value) begin
                     r.status    = (rq.kind == K_DISPLAY) ? ST_LISTED : ST_FOUND;
                     r.index     = 3'(i);
                     r.value_out = list_q[i];
                     r.last      = 1'b0;
                     step_rsp.push_back(r);
                  end
               end
               if (step_rsp.size() == 0) add_single(ST_NOTFOUND);
               else step_rsp[step_rsp.size() - 1].last = 1'b1;
            end
         end
         K_ROTATE: begin
            if (list_len == 0) begin
               add_single(ST_EMPTY);
            end else begin
               sh = int'(rq.rotate_count) % list_len;
               for (int i = 0; i < list_len; i++) rot_buf[(i + sh) % list_len] = list_q[i];
               for (int i = 0; i < list_len; i++) list_q[i] = rot_buf[i];
               add_single(ST_OK);
            end
         end
         default: ;   // unused kinds cause nothing
      endcase
   endfunction

   function automatic dir_row_type mk(input logic [3:0] k, input logic signed [31:0] v,
                                      input logic [3:0] p, input logic [7:0] rc,
                                      input bit t, input status_type st);
      dir_row_type d;
      d.rq.kind         = k;
      d.rq.value        = v;
      d.rq.position     = p;
      d.rq.rotate_count = rc;
      d.typed           = t;
      d.st              = st;
      return d;
   endfunction

   function automatic logic signed [31:0] pool_value();
      case ($urandom_range(0, 3))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return -32'sd1;
         default: return 32'sd7;
      endcase
   endfunction

   function automatic int draw_gap();
      return snd_burst ? 0 : $urandom_range(0, 9);
   endfunction

   // Random request, mostly well-formed for the current list, some noise
   function automatic req_type draw_req();
      req_type rq;
      int pick;
      int ins_weight;
      rq.kind         = K_DISPLAY;
      rq.value        = $urandom;
      rq.position     = 4'($urandom);
      rq.rotate_count = 8'($urandom);
      ins_weight = (list_len < 4) ? 45 : 25;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         rq.kind = 4'($urandom_range(int'(K_ROTATE) + 1, 15));
      end else if (pick < 3 + ins_weight) begin
         case ($urandom_range(0, 2))
            0: rq.kind = K_INS_FRONT;
            1: rq.kind = K_INS_BACK;
            default: rq.kind = K_INS_AT;
         endcase
         if ($urandom_range(0, 9) != 0) rq.position = 4'($urandom_range(1, list_len + 1));
         if ($urandom_range(0, 1) != 0) rq.value = pool_value();
      end else if (pick < 68) begin
         case ($urandom_range(0, 2))
            0: rq.kind = K_DEL_FRONT;
            1: rq.kind = K_DEL_BACK;
            default: rq.kind = K_DEL_AT;
         endcase
         if (list_len > 0 && $urandom_range(0, 9) != 0)
            rq.position = 4'($urandom_range(1, list_len));
      end else if (pick < 80) begin
         rq.kind = K_SEARCH;
         if (list_len > 0 && $urandom_range(0, 9) < 7)
            rq.value = list_q[$urandom_range(0, list_len - 1)];
         else if ($urandom_range(0, 1) != 0)
            rq.value = pool_value();
      end else if (pick < 90) begin
         rq.kind = K_DISPLAY;
      end else begin
         rq.kind = K_ROTATE;
         if ($urandom_range(0, 3) != 0) rq.rotate_count = 8'($urandom_range(0, 2 * list_len + 1));
      end
      return rq;
   endfunction

   // Offer one transaction after a gap; called and returns at a falling edge
   task automatic push_req(input req_type rq, input int gap, input bit typed,
                           input status_type st);
      rsp_type r;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_item <= rq;
      do @(posedge clock); while (req_full);
      apply_req(rq);
      if (typed) begin
         r.status    = st;
         r.index     = 3'd0;
         r.value_out = 32'sd0;
         r.last      = 1'b1;
         pending_rsp.push_back(r);
      end else begin
         foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
      end
      @(negedge clock);
   endtask

   // Sender idles until the core has returned everything owed
   task automatic drain_wait();
      req_push <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic check_rsp(input rsp_type got);
      rsp_type want;
      if (pending_rsp.size() == 0) begin
         $error("unexpected result: status %0d index %0d value_out %0d last %0d",
                got.status, got.index, got.value_out, got.last);
         n_errors++;
      end else begin
         want = pending_rsp.pop_front();
         if (got.status != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            n_errors++;
         end
         if (got.index != want.index) begin
            $error("index: expected %0d, actual %0d", want.index, got.index);
            n_errors++;
         end
         if (got.value_out != want.value_out) begin
            $error("value_out: expected %0d, actual %0d", want.value_out, got.value_out);
            n_errors++;
         end
         if (got.last != want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            n_errors++;
         end
      end
   endtask

   // Stimulus
   initial begin
      dir_row_type d;
      req_type rq;
      int n_sent;
      reset    = 1'b1;
      req_push = 1'b0;
      req_item = '0;
      rsp_pop  = 1'b0;
      n_errors = 0;
      list_len = 0;
      hold_req = 1'b0;
      snd_burst = 1'b0;
      rcv_burst = 1'b0;

      // empty list: every delete, scan and rotate reports empty
      dir_rows.push_back(mk(K_DISPLAY, 32'sd0, 4'd0, 8'd0, 1, ST_EMPTY));
      dir_rows.push_back(mk(K_SEARCH, 32'sd0, 4'd0, 8'd0, 1, ST_EMPTY));
      dir_rows.push_back(mk(K_DEL_FRONT, 32'sd0, 4'd0, 8'd0, 1, ST_EMPTY));
      dir_rows.push_back(mk(K_DEL_BACK, 32'sd0, 4'd0, 8'd0, 1, ST_EMPTY));
      dir_rows.push_back(mk(K_DEL_AT, 32'sd0, 4'd1, 8'd0, 1, ST_EMPTY));
      dir_rows.push_back(mk(K_ROTATE, 32'sd0, 4'd0, 8'd255, 1, ST_EMPTY));
      // insert at position 0 and beyond count + 1
      dir_rows.push_back(mk(K_INS_AT, 32'sd1, 4'd0, 8'd0, 1, ST_BADPOS));
      dir_rows.push_back(mk(K_INS_AT, 32'sd1, 4'd2, 8'd0, 1, ST_BADPOS));
      // value extremes, list becomes -1, max, min, 0
      dir_rows.push_back(mk(K_INS_FRONT, 32'sh7fffffff, 4'd0, 8'd0, 1, ST_OK));
      dir_rows.push_back(mk(K_INS_BACK, 32'sh80000000, 4'd0, 8'd0, 1, ST_OK));
      dir_rows.push_back(mk(K_INS_AT, 32'sd0, 4'd3, 8'd0, 1, ST_OK));
      dir_rows.push_back(mk(K_INS_AT, -32'sd1, 4'd1, 8'd0, 1, ST_OK));
      d = mk(K_DISPLAY, 32'sd0, 4'd0, 8'd0, 0, ST_OK);
      d.rq.kind = KIND_SPARE;
      dir_rows.push_back(d);
      dir_rows.push_back(mk(K_SEARCH, -32'sd1, 4'd0, 8'd0, 0, ST_OK));
      dir_rows.push_back(mk(K_SEARCH, 32'sd5, 4'd0, 8'd0, 1, ST_NOTFOUND));
      // fill to capacity with repeated values
      repeat (4) dir_rows.push_back(mk(K_INS_BACK, 32'sd5, 4'd0, 8'd0, 1, ST_OK));
      // full list reports full, ahead of a bad position
      dir_rows.push_back(mk(K_INS_FRONT, 32'sd9, 4'd0, 8'd0, 1, ST_FULL));
      dir_rows.push_back(mk(K_INS_AT, 32'sd9, 4'd15, 8'd0, 1, ST_FULL));
      dir_rows.push_back(mk(K_SEARCH, 32'sd5, 4'd0, 8'd0, 0, ST_OK));
      dir_rows.push_back(mk(K_ROTATE, 32'sd0, 4'd0, 8'd255, 1, ST_OK));
      dir_rows.push_back(mk(K_DISPLAY, 32'sd0, 4'd0, 8'd0, 0, ST_OK));
      dir_rows.push_back(mk(K_DEL_AT, 32'sd0, 4'd0, 8'd0, 1, ST_BADPOS));
      dir_rows.push_back(mk(K_DEL_AT, 32'sd0, 4'd8, 8'd0, 1, ST_OK));
      dir_rows.push_back(mk(K_DEL_FRONT, 32'sd0, 4'd0, 8'd0, 1, ST_OK));
      dir_rows.push_back(mk(K_DEL_BACK, 32'sd0, 4'd0, 8'd0, 1, ST_OK));
      dir_rows.push_back(mk(K_DISPLAY, 32'sd0, 4'd0, 8'd0, 0, ST_OK));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (dir_rows[i]) begin
         if (i % 8 == 0) snd_burst = ($urandom_range(0, 2) == 0);
         push_req(dir_rows[i].rq, draw_gap(), dir_rows[i].typed, dir_rows[i].st);
      end
      drain_wait();

      // random traffic
      n_sent = 0;
      while (n_sent < RANDOM_ITEMS) begin
         if (n_sent % 16 == 0) snd_burst = ($urandom_range(0, 2) == 0);
         if (n_sent == 20) begin
            hold_req  = 1'b1;   // receiver stalls while requests keep coming
            snd_burst = 1'b1;
         end
         if (n_sent == 80) drain_wait();
         rq = draw_req();
         push_req(rq, draw_gap(), 1'b0, ST_OK);
         if (rq.kind <= K_ROTATE) n_sent++;
      end
      req_push <= 1'b0;

      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (n_errors == 0) begin
         $display("bounded_array_list_engine_core: match");
      end else begin
         $display("bounded_array_list_engine_core: mismatch");
      end
      $finish;
   end

   // Result side: random pop stalls, one long hold-off on request
   initial begin
      int stall;
      int n_rcv;
      n_rcv = 0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (n_rcv % 16 == 0) rcv_burst = ($urandom_range(0, 2) == 0);
         stall = rcv_burst ? 0 : $urandom_range(0, 9);
         if (hold_req) begin
            hold_req = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         check_rsp(rsp_item);
         n_rcv++;
         @(negedge clock);
      end
   end

   // Watchdog
   initial begin
      #5000000;
      $display("bounded_array_list_engine_core: mismatch");
      $finish;
   end

endmodule
